@@ hw/rtl/line_follower_steering_defines.svh @@
// Assertion macros shared by the line follower steering checker.
`ifndef LINE_FOLLOWER_STEERING_DEFINES_SVH
`define LINE_FOLLOWER_STEERING_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define LFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define LFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lfs_pkg.sv @@
// Types, codes and steering table for the line follower steering block.
`default_nettype none
package lfs_pkg;

    localparam int unsigned PatW   = 8;
    localparam int unsigned SpeedW = 8;
    localparam int unsigned SumW   = 9;
    localparam int unsigned CountW = 12;
    localparam int unsigned BaseW  = 7;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 12;

    localparam logic [CountW-1:0] COUNT_MAX      = 12'd4095;
    localparam logic [CountW-1:0] LOST_LIMIT_RST = 12'd1200;

    localparam logic [PatW-1:0] PAT_ALL_DARK   = 8'h00;
    localparam logic [PatW-1:0] PAT_ALL_LIGHT  = 8'hFF;
    localparam logic [PatW-1:0] PAT_RFID_MASK  = 8'h18;

    localparam logic signed [SumW-1:0] SPEED_MAX = 9'sd100;
    localparam logic signed [SumW-1:0] SPEED_MIN = 9'sd5;

    // stop codes
    localparam logic [1:0] STOP_NONE = 2'd0;
    localparam logic [1:0] STOP_DARK = 2'd1;
    localparam logic [1:0] STOP_RFID = 2'd2;
    localparam logic [1:0] STOP_LOST = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_BASE_SPEED  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RFID_ENABLE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LOST_LIMIT  = 2'd2;

    typedef struct packed {
        logic [PatW-1:0] sensor_pattern;
        logic            start_tracking;
    } t_in_item;

    typedef struct packed {
        logic                     motor_write;
        logic signed [SpeedW-1:0] left_speed;
        logic signed [SpeedW-1:0] right_speed;
        logic [1:0]               stop_code;
        logic                     tracking_active;
    } t_out_item;

    typedef struct packed {
        logic [BaseW-1:0]  base_speed;
        logic              rfid_stop_enable;
        logic [CountW-1:0] lost_line_limit;
    } t_cfg;

    typedef struct packed {
        logic              tracking;
        logic [CountW-1:0] all_ones_ticks;
    } t_state;

    typedef struct packed {
        logic signed [SpeedW-1:0] dl;
        logic signed [SpeedW-1:0] dr;
    } t_offsets;

    function automatic t_offsets steer_offsets(input logic [PatW-1:0] p);
        t_offsets o;
        o.dl = '0;
        o.dr = '0;
        unique case (p)
            8'hF7, 8'hF3: begin o.dl = 8'sd20;  o.dr = -8'sd40;  end
            8'hFB, 8'hF9: begin o.dl = 8'sd40;  o.dr = -8'sd60;  end
            8'hFD, 8'hFC: begin o.dl = 8'sd60;  o.dr = -8'sd90;  end
            8'hFE:        begin o.dl = 8'sd80;  o.dr = -8'sd120; end
            8'hEF, 8'hCF: begin o.dr = 8'sd20;  o.dl = -8'sd40;  end
            8'hDF, 8'h9F: begin o.dr = 8'sd40;  o.dl = -8'sd60;  end
            8'hBF, 8'h3F: begin o.dr = 8'sd60;  o.dl = -8'sd90;  end
            8'h7F:        begin o.dr = 8'sd80;  o.dl = -8'sd120; end
            default: ;
        endcase
        return o;
    endfunction

    // Keep the magnitude within MIN..MAX, sign preserved.
    function automatic logic signed [SpeedW-1:0] clamp_speed(
        input logic signed [SumW-1:0] v
    );
        logic signed [SumW-1:0] r;
        r = v;
        if (v >= 0) begin
            if (v > SPEED_MAX) r = SPEED_MAX;
            if (v < SPEED_MIN) r = SPEED_MIN;
        end else begin
            if (v < -SPEED_MAX) r = -SPEED_MAX;
            if (v > -SPEED_MIN) r = -SPEED_MIN;
        end
        return r[SpeedW-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lfs_steer.sv @@
// Per-item steering decision: pattern table, speed clamp, stop causes, next state.
`default_nettype none
module lfs_steer (
    input  wire lfs_pkg::t_in_item  i_item,
    input  wire lfs_pkg::t_state    i_state,
    input  wire lfs_pkg::t_cfg      i_cfg,
    output lfs_pkg::t_out_item      o_result,
    output lfs_pkg::t_state         o_state
);

    logic                               w_track;
    logic [lfs_pkg::PatW-1:0]           w_p;
    lfs_pkg::t_offsets                  w_off;
    logic signed [lfs_pkg::SumW-1:0]    w_base;
    logic signed [lfs_pkg::SumW-1:0]    w_lsum;
    logic signed [lfs_pkg::SumW-1:0]    w_rsum;
    logic [1:0]                         w_stop;
    logic [lfs_pkg::CountW-1:0]         w_cnt;

    assign w_p     = i_item.sensor_pattern;
    assign w_track = i_state.tracking | i_item.start_tracking;
    assign w_off   = lfs_pkg::steer_offsets(w_p);
    assign w_base  = $signed({2'b00, i_cfg.base_speed});
    assign w_lsum  = w_base + lfs_pkg::SumW'(w_off.dl);
    assign w_rsum  = w_base + lfs_pkg::SumW'(w_off.dr);

    always_comb begin
        w_stop = lfs_pkg::STOP_NONE;
        w_cnt  = '0;
        if (w_p == lfs_pkg::PAT_ALL_DARK) begin
            w_stop = lfs_pkg::STOP_DARK;
        end else if (i_cfg.rfid_stop_enable
                     && ((w_p & lfs_pkg::PAT_RFID_MASK) == lfs_pkg::PAT_RFID_MASK)
                     && (!w_p[7] || !w_p[0])) begin
            w_stop = lfs_pkg::STOP_RFID;
        end
        if (w_p == lfs_pkg::PAT_ALL_LIGHT) begin
            if (i_state.all_ones_ticks > i_cfg.lost_line_limit) begin
                w_stop = lfs_pkg::STOP_LOST;
            end else if (i_state.all_ones_ticks < lfs_pkg::COUNT_MAX) begin
                w_cnt = i_state.all_ones_ticks + 1'b1;
            end else begin
                w_cnt = i_state.all_ones_ticks;
            end
        end
    end

    always_comb begin
        o_result = '0;
        o_state  = i_state;
        if (w_track) begin
            o_result.motor_write = 1'b1;
            o_result.stop_code   = w_stop;
            o_state.all_ones_ticks = w_cnt;
            if (w_stop != lfs_pkg::STOP_NONE) begin
                o_state.tracking = 1'b0;
            end else begin
                o_state.tracking     = 1'b1;
                o_result.left_speed  = lfs_pkg::clamp_speed(w_lsum);
                o_result.right_speed = lfs_pkg::clamp_speed(w_rsum);
            end
        end
        o_result.tracking_active = o_state.tracking;
    end

endmodule
`default_nettype wire

@@ hw/rtl/line_follower_steering.sv @@
// Top level of the line follower steering block: item registers, state, config.
//
//   channel  dir  handshake               payload
//   in       in   i_in_valid / o_in_stall  i_in_item  (lfs_pkg::t_in_item)
//   out      out  o_out_valid / i_out_stall o_out_item (lfs_pkg::t_out_item)
//   cfg      in   i_cfg_we                 i_cfg_idx, i_cfg_wdata
//
// One item per cycle sustained while the output is not stalled; an item is
// accepted into the input register, passes the steering logic and is held
// in the result register. Tracking state advances as each item moves
// into the result register. Synchronous active-low reset clears state, valids
// and configuration (lost_line_limit to 1200). A stalled output holds its
// result; the input register still takes one more item before the input stalls.
`default_nettype none
module line_follower_steering (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire lfs_pkg::t_in_item                i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output lfs_pkg::t_out_item                    o_out_item,
    input  wire                                   i_cfg_we,
    input  wire [lfs_pkg::CfgIdxW-1:0]            i_cfg_idx,
    input  wire [lfs_pkg::CfgDataW-1:0]           i_cfg_wdata
);

    logic                r_in_valid;
    lfs_pkg::t_in_item   r_in;
    logic                r_out_valid;
    lfs_pkg::t_out_item  r_out;
    lfs_pkg::t_state     r_state;
    lfs_pkg::t_cfg       r_cfg;

    lfs_pkg::t_out_item  n_out;
    lfs_pkg::t_state     n_state;

    logic w_move;
    logic w_accept;

    assign w_move     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    lfs_steer u_steer (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_result (n_out),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_cfg.base_speed       <= '0;
            r_cfg.rfid_stop_enable <= 1'b0;
            r_cfg.lost_line_limit  <= lfs_pkg::LOST_LIMIT_RST;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lfs_pkg::CFG_BASE_SPEED:
                        r_cfg.base_speed <= i_cfg_wdata[lfs_pkg::BaseW-1:0];
                    lfs_pkg::CFG_RFID_ENABLE:
                        r_cfg.rfid_stop_enable <= i_cfg_wdata[0];
                    lfs_pkg::CFG_LOST_LIMIT:
                        r_cfg.lost_line_limit <= i_cfg_wdata[lfs_pkg::CountW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

@@ hw/rtl/lfs_checker.sv @@
// Port-level checks for the line follower steering block, bound to the top level.
`default_nettype none
`include "line_follower_steering_defines.svh"
module lfs_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire lfs_pkg::t_out_item      o_out_item
);

    logic w_stop_item;
    logic w_idle_item;
    logic w_drive_item;
    logic w_out_held;
    logic w_zero_cmd;
    logic w_stop_ok;
    logic w_idle_ok;
    logic w_drive_ok;

    assign w_stop_item  = o_out_valid && (o_out_item.stop_code != lfs_pkg::STOP_NONE);
    assign w_idle_item  = o_out_valid && !o_out_item.motor_write;
    assign w_drive_item = o_out_valid && o_out_item.motor_write
                          && (o_out_item.stop_code == lfs_pkg::STOP_NONE);
    assign w_out_held   = o_out_valid && i_out_stall;

    assign w_zero_cmd = (o_out_item.left_speed == 8'sd0) && (o_out_item.right_speed == 8'sd0);
    assign w_stop_ok  = o_out_item.motor_write && w_zero_cmd && !o_out_item.tracking_active;
    assign w_idle_ok  = w_zero_cmd && (o_out_item.stop_code == lfs_pkg::STOP_NONE)
                        && !o_out_item.tracking_active;
    // drive speeds are clamped away from zero
    assign w_drive_ok = o_out_item.tracking_active
                        && (o_out_item.left_speed != 8'sd0)
                        && (o_out_item.right_speed != 8'sd0)
                        && (o_out_item.left_speed <= 8'sd100)
                        && (o_out_item.left_speed >= -8'sd100);

    `LFS_ASSERT_NOW(a_stop_zero_cmd, i_clk, i_rst_n, w_stop_item, w_stop_ok, "stop item not zeroed")
    `LFS_ASSERT_NOW(a_idle_all_zero, i_clk, i_rst_n, w_idle_item, w_idle_ok, "idle item not zeroed")
    `LFS_ASSERT_NOW(a_drive_in_range, i_clk, i_rst_n, w_drive_item, w_drive_ok, "bad drive speed")
    `LFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_held, $stable(o_out_item), "item moved")
    `LFS_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, w_out_held, o_out_valid, "valid dropped")

endmodule

bind line_follower_steering lfs_checker u_lfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
